// File: hdl/obstacle_avoid_motor_drive_assert.svh
// assertion macros for the obstacle avoid motor drive
// used by the top level; no other dependencies
`ifndef OBSTACLE_AVOID_MOTOR_DRIVE_ASSERT_SVH
`define OBSTACLE_AVOID_MOTOR_DRIVE_ASSERT_SVH

`ifndef SYNTHESIS

`define OAMD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define OAMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define OAMD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)

`define OAMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: hdl/oamd_pkg.sv
// shared types, constants and helpers for the obstacle avoid motor drive
// no dependencies
`default_nettype none

package oamd_pkg;

   localparam int unsigned DIST_W  = 10;
   localparam int unsigned SPEED_W = 7;
   localparam int unsigned TRIG_W  = 9;

   localparam logic [TRIG_W-1:0] TRIG_RESET = 9'd25;

   localparam logic signed [DIST_W-1:0] WALL_DIST = 10'sd35;
   localparam logic signed [DIST_W-1:0] MAP_LO    = 10'sd10;
   localparam logic signed [DIST_W-1:0] OPEN_NEAR = 10'sd40;
   localparam logic signed [DIST_W-1:0] OPEN_FAR  = 10'sd80;

   typedef struct packed {
      logic signed [SPEED_W-1:0] left;
      logic signed [SPEED_W-1:0] right;
   } speed_pair_type;

   // floor(n / 5) for n below 256, by reciprocal multiply
   function automatic logic [5:0] div5(input logic [7:0] n);
      logic [15:0] prod;
      prod = 16'(n) * 16'd205;
      return prod[15:10];
   endfunction

   // offset into the linear map span, clamped at the low end
   function automatic logic [4:0] map_offset(input logic signed [DIST_W-1:0] x);
      logic signed [DIST_W-1:0] t;
      t = x - MAP_LO;
      if (x < MAP_LO) begin
         return 5'd0;
      end
      return t[4:0];
   endfunction

endpackage

`default_nettype wire

// File: hdl/oamd_speed.sv
// wheel speed table for avoid mode, selected by the wall code
// depends on oamd_pkg
`default_nettype none

module oamd_speed
   import oamd_pkg::*;
(
   input  wire logic signed [DIST_W-1:0] front,
   input  wire logic signed [DIST_W-1:0] left,
   input  wire logic signed [DIST_W-1:0] right,
   output speed_pair_type                speed
);

   localparam logic [2:0] WALL_NONE = 3'd0;
   localparam logic [2:0] WALL_F    = 3'd1;
   localparam logic [2:0] WALL_R    = 3'd2;
   localparam logic [2:0] WALL_RF   = 3'd3;
   localparam logic [2:0] WALL_L    = 3'd4;
   localparam logic [2:0] WALL_LF   = 3'd5;
   localparam logic [2:0] WALL_LR   = 3'd6;
   localparam logic [2:0] WALL_ALL  = 3'd7;

   logic [2:0]                 code;
   logic signed [DIST_W-1:0]   min_lf;
   logic signed [DIST_W-1:0]   min_rf;
   logic [4:0]                 d_lf;
   logic [4:0]                 d_l;
   logic [4:0]                 d_rf;
   logic [4:0]                 d_r;
   logic [4:0]                 d_f;
   logic signed [SPEED_W-1:0]  q_lf;
   logic signed [SPEED_W-1:0]  q_l;
   logic signed [SPEED_W-1:0]  q_rf;
   logic signed [SPEED_W-1:0]  q_r;
   logic signed [SPEED_W-1:0]  q_f;

   assign code = {left <= WALL_DIST, right <= WALL_DIST, front <= WALL_DIST};

   assign min_lf = (left < front) ? left : front;
   assign min_rf = (right < front) ? right : front;

   assign d_lf = map_offset(min_lf);
   assign d_l  = map_offset(left);
   assign d_rf = map_offset(min_rf);
   assign d_r  = map_offset(right);
   assign d_f  = map_offset(front);

   // slopes of -20/25, -10/25 and -40/25, truncated toward zero
   assign q_lf = {1'b0, div5({1'b0, d_lf, 2'b00})};
   assign q_l  = {1'b0, div5({1'b0, d_l, 2'b00})};
   assign q_rf = {1'b0, div5({2'b00, d_rf, 1'b0})};
   assign q_r  = {1'b0, div5({1'b0, d_r, 2'b00})};
   assign q_f  = {1'b0, div5({d_f, 3'b000})};

   always_comb begin
      speed.left  = 7'sd20;
      speed.right = 7'sd20;
      unique case (code)
         WALL_ALL: begin
            speed.left  = 7'sd30;
            speed.right = -7'sd20;
         end
         WALL_LR: begin
            speed.left  = 7'sd0;
            speed.right = 7'sd0;
         end
         WALL_LF: begin
            speed.left  = 7'sd35 - q_lf;
            speed.right = q_lf - 7'sd35;
         end
         WALL_L: begin
            speed.left = 7'sd45 - q_l;
         end
         WALL_RF: begin
            speed.right = 7'sd35 - q_rf;
         end
         WALL_R: begin
            speed.right = 7'sd45 - q_r;
         end
         WALL_F: begin
            speed.left = 7'sd45 - q_f;
         end
         WALL_NONE: begin
            if (left >= OPEN_NEAR) begin
               speed.right = (left < OPEN_FAR) ? 7'sd45 : 7'sd25;
            end
         end
         default: begin
            speed.left  = 7'sd20;
            speed.right = 7'sd20;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: hdl/obstacle_avoid_motor_drive.sv
// obstacle avoid motor drive top level: input register, mode logic, result register
// depends on oamd_pkg, oamd_speed and obstacle_avoid_motor_drive_assert.svh
//
// Each item is registered on entry, evaluated against the search/avoid mode and the
// trigger distance, and lands in the result register, giving exactly one result per
// item. An item is accepted every cycle while results are taken; the result is valid
// once the item has passed the input and result registers. The mode flag updates as
// an item moves into the result register, so back-to-back items see the mode left by
// the item before them. The trigger distance is written through the csr port, which
// is always ready.
`default_nettype none

module obstacle_avoid_motor_drive
   import oamd_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,

   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [TRIG_W-1:0]          csr_trigger_distance,

   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_tick,
   input  wire logic signed [DIST_W-1:0]   req_front_distance,
   input  wire logic signed [DIST_W-1:0]   req_left_distance,
   input  wire logic signed [DIST_W-1:0]   req_right_distance,

   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic                            rsp_drive_valid,
   output logic signed [SPEED_W-1:0]       rsp_left_speed,
   output logic signed [SPEED_W-1:0]       rsp_right_speed,
   output logic                            rsp_reading_error,
   output logic                            rsp_avoiding
);

`include "obstacle_avoid_motor_drive_assert.svh"

   logic [TRIG_W-1:0]         trig_ff;
   logic                      mode_ff;
   logic                      mode_in;

   logic                      s1_valid_ff;
   logic                      s1_tick_ff;
   logic signed [DIST_W-1:0]  s1_front_ff;
   logic signed [DIST_W-1:0]  s1_left_ff;
   logic signed [DIST_W-1:0]  s1_right_ff;

   logic                      s2_valid_ff;
   logic                      drive_ff;
   logic                      drive_in;
   logic signed [SPEED_W-1:0] lspeed_ff;
   logic signed [SPEED_W-1:0] rspeed_ff;
   logic                      err_ff;
   logic                      err_in;
   logic                      avoid_ff;

   logic                      advance;
   logic                      take_req;
   logic signed [DIST_W-1:0]  trig_s;
   logic                      hit;
   logic                      negative;
   speed_pair_type            speed;

   assign csr_ready = 1'b1;

   assign advance   = s1_valid_ff && (!s2_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign take_req  = req_valid && req_ready;

   assign trig_s   = {1'b0, trig_ff};
   assign hit      = (s1_front_ff <= trig_s) || (s1_left_ff <= trig_s)
                     || (s1_right_ff <= trig_s);
   assign negative = s1_front_ff[DIST_W-1] || s1_left_ff[DIST_W-1]
                     || s1_right_ff[DIST_W-1];

   oamd_speed u_speed (
      .front (s1_front_ff),
      .left  (s1_left_ff),
      .right (s1_right_ff),
      .speed (speed)
   );

   always_comb begin
      mode_in  = mode_ff;
      drive_in = 1'b0;
      err_in   = 1'b0;
      if (s1_tick_ff) begin
         if (!mode_ff) begin
            mode_in = hit;
         end else if (negative) begin
            err_in = 1'b1;
         end else begin
            drive_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ff     <= TRIG_RESET;
         mode_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            trig_ff <= csr_trigger_distance;
         end
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            mode_ff     <= mode_in;
            s2_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            s2_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         s1_tick_ff  <= req_tick;
         s1_front_ff <= req_front_distance;
         s1_left_ff  <= req_left_distance;
         s1_right_ff <= req_right_distance;
      end
      if (advance) begin
         drive_ff  <= drive_in;
         err_ff    <= err_in;
         avoid_ff  <= mode_in;
         lspeed_ff <= drive_in ? speed.left : '0;
         rspeed_ff <= drive_in ? speed.right : '0;
      end
   end

   assign rsp_valid         = s2_valid_ff;
   assign rsp_drive_valid   = drive_ff;
   assign rsp_left_speed    = lspeed_ff;
   assign rsp_right_speed   = rspeed_ff;
   assign rsp_reading_error = err_ff;
   assign rsp_avoiding      = avoid_ff;

   `OAMD_ASSERT_IMPLY(a_drive_in_avoid, clock, reset, rsp_valid && rsp_drive_valid, rsp_avoiding, "drive issued outside avoid mode")
   `OAMD_ASSERT_IMPLY(a_error_no_drive, clock, reset, rsp_valid && rsp_reading_error, !rsp_drive_valid && rsp_avoiding, "reading error with drive or in search mode")
   `OAMD_ASSERT_IMPLY(a_idle_speeds_zero, clock, reset, rsp_valid && !rsp_drive_valid, rsp_left_speed == 7'sd0 && rsp_right_speed == 7'sd0, "nonzero speed without drive")
   `OAMD_ASSERT_NEXT(a_mode_sticky, clock, reset, mode_ff, mode_ff, "avoid mode dropped")

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// self-checking testbench for the obstacle avoid motor drive: drives readings items,
// predicts mode and wheel speeds for each accepted item and checks every result in order
// depends on oamd_pkg and the obstacle_avoid_motor_drive top level
`default_nettype none

module tb;
   import oamd_pkg::*;

   typedef struct {
      logic                      drive_valid;
      logic signed [SPEED_W-1:0] left_speed;
      logic signed [SPEED_W-1:0] right_speed;
      logic                      reading_error;
      logic                      avoiding;
   } drive_cmd_type;

   localparam logic [2:0] WALLS_NONE        = 3'd0;
   localparam logic [2:0] WALLS_FRONT       = 3'd1;
   localparam logic [2:0] WALLS_RIGHT       = 3'd2;
   localparam logic [2:0] WALLS_RIGHT_FRONT = 3'd3;
   localparam logic [2:0] WALLS_LEFT        = 3'd4;
   localparam logic [2:0] WALLS_LEFT_FRONT  = 3'd5;
   localparam logic [2:0] WALLS_LEFT_RIGHT  = 3'd6;
   localparam logic [2:0] WALLS_ALL         = 3'd7;

   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset;

   logic                      csr_valid;
   logic                      csr_ready;
   logic [TRIG_W-1:0]         csr_trigger_distance;

   logic                      req_valid;
   logic                      req_ready;
   logic                      req_tick;
   logic signed [DIST_W-1:0]  req_front_distance;
   logic signed [DIST_W-1:0]  req_left_distance;
   logic signed [DIST_W-1:0]  req_right_distance;

   logic                      rsp_valid;
   logic                      rsp_ready;
   logic                      rsp_drive_valid;
   logic signed [SPEED_W-1:0] rsp_left_speed;
   logic signed [SPEED_W-1:0] rsp_right_speed;
   logic                      rsp_reading_error;
   logic                      rsp_avoiding;

   drive_cmd_type     speed_cmds_due[$];
   drive_cmd_type     got_cmd;
   drive_cmd_type     want_cmd;
   logic              pred_avoid;
   logic [TRIG_W-1:0] pred_trigger;
   int                fail_count;
   int                cycle_count;
   int                rsp_hold;
   bit                no_gaps;

   obstacle_avoid_motor_drive u_top (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_trigger_distance (csr_trigger_distance),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_tick             (req_tick),
      .req_front_distance   (req_front_distance),
      .req_left_distance    (req_left_distance),
      .req_right_distance   (req_right_distance),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_drive_valid      (rsp_drive_valid),
      .rsp_left_speed       (rsp_left_speed),
      .rsp_right_speed      (rsp_right_speed),
      .rsp_reading_error    (rsp_reading_error),
      .rsp_avoiding         (rsp_avoiding)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout at %0t", $time);
         $display("Some tests failed");
         $finish;
      end
   end

   // clamped linear map over the wall span, truncating division
   function automatic int span_map(input int x, input int p, input int q);
      if (x < int'(MAP_LO)) begin
         return p;
      end
      if (x > int'(WALL_DIST)) begin
         return q;
      end
      return (x - int'(MAP_LO)) * (q - p) / (int'(WALL_DIST) - int'(MAP_LO)) + p;
   endfunction

   function automatic drive_cmd_type predict_drive(input logic tick, input int f, input int l,
                                                   input int r);
      drive_cmd_type c;
      int            ls;
      int            rs;
      logic [2:0]    walls;
      ls = 0;
      rs = 0;
      c.drive_valid = 1'b0;
      c.reading_error = 1'b0;
      if (tick) begin
         if (!pred_avoid) begin
            if (f <= int'(pred_trigger) || l <= int'(pred_trigger) ||
                r <= int'(pred_trigger)) begin
               pred_avoid = 1'b1;
            end
         end else if (f < 0 || l < 0 || r < 0) begin
            c.reading_error = 1'b1;
         end else begin
            c.drive_valid = 1'b1;
            walls = {l <= int'(WALL_DIST), r <= int'(WALL_DIST), f <= int'(WALL_DIST)};
            ls = 20;
            rs = 20;
            case (walls)
               WALLS_ALL: begin
                  ls = 30;
                  rs = -20;
               end
               WALLS_LEFT_RIGHT: begin
                  ls = 0;
                  rs = 0;
               end
               WALLS_LEFT_FRONT: begin
                  ls = span_map((l < f) ? l : f, 35, 15);
                  rs = -ls;
               end
               WALLS_LEFT: ls = 20 + span_map(l, 25, 5);
               WALLS_RIGHT_FRONT: rs = 20 + span_map((r < f) ? r : f, 15, 5);
               WALLS_RIGHT: rs = 20 + span_map(r, 25, 5);
               WALLS_FRONT: ls = 20 + span_map(f, 25, -15);
               WALLS_NONE: begin
                  if (l >= int'(OPEN_NEAR)) begin
                     rs = (l < int'(OPEN_FAR)) ? 45 : 25;
                  end
               end
               default: ;
            endcase
         end
      end
      c.left_speed = SPEED_W'(ls);
      c.right_speed = SPEED_W'(rs);
      c.avoiding = pred_avoid;
      return c;
   endfunction

   // result side: random stall per item, checks against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_cmd.drive_valid = rsp_drive_valid;
            got_cmd.left_speed = rsp_left_speed;
            got_cmd.right_speed = rsp_right_speed;
            got_cmd.reading_error = rsp_reading_error;
            got_cmd.avoiding = rsp_avoiding;
            if (speed_cmds_due.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected item, got drive_valid %0b speeds %0d/%0d err %0b avoid %0b",
                        $time, got_cmd.drive_valid, got_cmd.left_speed, got_cmd.right_speed,
                        got_cmd.reading_error, got_cmd.avoiding);
            end else begin
               want_cmd = speed_cmds_due.pop_front();
               if (got_cmd.drive_valid !== want_cmd.drive_valid) begin
                  fail_count++;
                  $display("%0t: drive_valid expected %0b, got %0b", $time,
                           want_cmd.drive_valid, got_cmd.drive_valid);
               end
               if (got_cmd.left_speed !== want_cmd.left_speed) begin
                  fail_count++;
                  $display("%0t: left_speed expected %0d, got %0d", $time,
                           want_cmd.left_speed, got_cmd.left_speed);
               end
               if (got_cmd.right_speed !== want_cmd.right_speed) begin
                  fail_count++;
                  $display("%0t: right_speed expected %0d, got %0d", $time,
                           want_cmd.right_speed, got_cmd.right_speed);
               end
               if (got_cmd.reading_error !== want_cmd.reading_error) begin
                  fail_count++;
                  $display("%0t: reading_error expected %0b, got %0b", $time,
                           want_cmd.reading_error, got_cmd.reading_error);
               end
               if (got_cmd.avoiding !== want_cmd.avoiding) begin
                  fail_count++;
                  $display("%0t: avoiding expected %0b, got %0b", $time,
                           want_cmd.avoiding, got_cmd.avoiding);
               end
            end
            rsp_hold = no_gaps ? 0 : $urandom_range(0, 9);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_ready <= (rsp_hold == 0);
      end
   end

   task automatic send_item(input logic tick, input logic signed [DIST_W-1:0] f,
                            input logic signed [DIST_W-1:0] l,
                            input logic signed [DIST_W-1:0] r);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_tick <= tick;
      req_front_distance <= f;
      req_left_distance <= l;
      req_right_distance <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      speed_cmds_due.push_back(predict_drive(tick, f, l, r));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (speed_cmds_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_trigger(input logic [TRIG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_trigger_distance <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      pred_trigger = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [DIST_W-1:0] rand_reading();
      case ($urandom_range(0, 19))
         0: return DIST_W'($urandom_range(0, 1023));
         1: return -DIST_W'($urandom_range(1, 512));
         2: return DIST_W'($urandom_range(0, 511));
         default: return DIST_W'($urandom_range(0, 100));
      endcase
   endfunction

   task automatic test_reset_trigger();
      send_item(1'b1, 10'sd26, 10'sd26, 10'sd26);
      send_item(1'b1, 10'sd511, 10'sd511, 10'sd511);
      send_item(1'b0, -10'sd512, -10'sd512, -10'sd512);
      send_item(1'b0, 10'sd0, 10'sd0, 10'sd0);
   endtask

   task automatic test_trigger_extremes();
      drain_results();
      write_trigger(9'd0);
      send_item(1'b1, 10'sd1, 10'sd1, 10'sd1);
      send_item(1'b1, 10'sd1, 10'sd511, 10'sd1);
      drain_results();
      write_trigger(9'd510);
      send_item(1'b1, 10'sd511, 10'sd511, 10'sd511);
      send_item(1'b0, 10'sd0, -10'sd1, 10'sd7);
   endtask

   task automatic test_search_random();
      logic [TRIG_W-1:0] trig;
      logic              tick;
      for (int phase = 0; phase < 6; phase++) begin
         drain_results();
         trig = TRIG_W'($urandom_range(0, 510));
         write_trigger(trig);
         for (int n = 0; n < 15; n++) begin
            tick = $urandom_range(0, 3) != 0;
            if (tick) begin
               send_item(1'b1, DIST_W'($urandom_range(int'(trig) + 1, 511)),
                         DIST_W'($urandom_range(int'(trig) + 1, 511)),
                         DIST_W'($urandom_range(int'(trig) + 1, 511)));
            end else begin
               send_item(1'b0, DIST_W'($urandom), DIST_W'($urandom), DIST_W'($urandom));
            end
         end
      end
   endtask

   // a negative reading counts as below the trigger
   task automatic test_mode_switch();
      drain_results();
      write_trigger(9'd0);
      send_item(1'b1, 10'sd10, -10'sd512, 10'sd10);
      send_item(1'b1, 10'sd511, 10'sd511, 10'sd511);
   endtask

   task automatic test_avoid_codes();
      send_item(1'b1, 10'sd35, 10'sd35, 10'sd35);
      send_item(1'b1, 10'sd0, 10'sd0, 10'sd0);
      send_item(1'b1, 10'sd36, 10'sd35, 10'sd35);
      send_item(1'b1, 10'sd10, 10'sd10, 10'sd36);
      send_item(1'b1, 10'sd22, 10'sd30, 10'sd36);
      send_item(1'b1, 10'sd36, 10'sd0, 10'sd36);
      send_item(1'b1, 10'sd36, 10'sd23, 10'sd36);
      send_item(1'b1, 10'sd12, 10'sd36, 10'sd33);
      send_item(1'b1, 10'sd36, 10'sd36, 10'sd35);
      send_item(1'b1, 10'sd36, 10'sd36, 10'sd17);
      send_item(1'b1, 10'sd35, 10'sd36, 10'sd36);
      send_item(1'b1, 10'sd11, 10'sd36, 10'sd36);
      send_item(1'b1, 10'sd36, 10'sd39, 10'sd36);
      send_item(1'b1, 10'sd36, 10'sd40, 10'sd36);
      send_item(1'b1, 10'sd36, 10'sd79, 10'sd36);
      send_item(1'b1, 10'sd36, 10'sd80, 10'sd36);
   endtask

   task automatic test_avoid_errors();
      send_item(1'b1, -10'sd1, 10'sd50, 10'sd50);
      send_item(1'b1, 10'sd50, 10'sd50, -10'sd512);
      send_item(1'b1, 10'sd0, -10'sd1, 10'sd0);
      send_item(1'b0, -10'sd5, 10'sd3, 10'sd511);
   endtask

   task automatic test_avoid_random();
      int   ticks;
      int   chunk;
      logic tick;
      ticks = 0;
      chunk = 0;
      while (ticks < 1600) begin
         drain_results();
         case (chunk % 4)
            0: write_trigger(9'd511);
            1: write_trigger(9'd0);
            default: write_trigger(TRIG_W'($urandom_range(0, 511)));
         endcase
         no_gaps = (chunk % 3) == 2;
         for (int n = 0; n < 200; n++) begin
            tick = $urandom_range(0, 9) != 0;
            send_item(tick, rand_reading(), rand_reading(), rand_reading());
            if (tick) begin
               ticks++;
            end
            // sender holds off until everything outstanding is back
            if (n == 100 && chunk == 1) begin
               drain_results();
            end
         end
         chunk++;
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_trigger_distance = '0;
      req_valid = 1'b0;
      req_tick = 1'b0;
      req_front_distance = '0;
      req_left_distance = '0;
      req_right_distance = '0;
      pred_avoid = 1'b0;
      pred_trigger = TRIG_RESET;
      fail_count = 0;
      cycle_count = 0;
      no_gaps = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_trigger();
      test_trigger_extremes();
      test_search_random();
      test_mode_switch();
      test_avoid_codes();
      test_avoid_errors();
      test_avoid_random();

      drain_results();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: obstacle_avoid_motor_drive.f
+incdir+hdl
hdl/oamd_pkg.sv
hdl/oamd_speed.sv
hdl/obstacle_avoid_motor_drive.sv
tb/sv/tb.sv
